// ----- sv/rdch_pkg.sv -----
// Shared types, codes and helpers for the ray to disk closest hit block.
package rdch_pkg;

    localparam int WORD_W = 32;
    localparam int ACC_W = 64;
    localparam int ENTRY_W = 7 * WORD_W;
    localparam int QUOT_W = 31;

    // Datapath phases that share the multiplier.
    localparam logic [1:0] PH_DEN = 2'd0;
    localparam logic [1:0] PH_NUM = 2'd1;
    localparam logic [1:0] PH_PC  = 2'd2;
    localparam logic [1:0] PH_SQ  = 2'd3;

    localparam logic [1:0] LANE_LAST = 2'd3;

    typedef struct packed {
        logic       load_we;
        logic       start;
        logic       mem_re;
        logic       mac;
        logic [1:0] phase;
        logic [1:0] lane;
        logic       div_init;
        logic       div_step;
        logic       upd;
        logic       out_load;
    } rdch_cmd_t;

    typedef struct packed {
        logic den_zero;
        logic sign_miss;
    } rdch_sts_t;

    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(64'sd2147483647);
        lo = -ACC_W'(64'sd2147483648);
        if (v > hi)
        begin
            return 32'sh7FFFFFFF;
        end
        else if (v < lo)
        begin
            return 32'sh80000000;
        end
        return v[WORD_W-1:0];
    endfunction

endpackage

// ----- sv/ray_disk_closest_hit.sv -----
// Top level of the ray to disk closest hit block.
//
// The input channel carries two kinds of item. A load item (kind 0) writes one
// disk table entry and is finished in the cycle it is accepted. A query item
// (kind 1) walks the first disk_count entries and yields one result item with the
// hit flag, the index of the closest disk and the new best distance.
// The walk stops after MAX_DISKS entries when disk_count is larger. A disk
// that goes the whole way takes one table read, four passes through the single
// 32 by 32 multiplier, the restoring divider that produces one quotient bit a
// cycle, and an update step. A parallel ray leaves a disk after the second
// multiplier pass, a disk behind the origin after the divider. The result of a
// query becomes valid in the same cycle as the input opens again.
// The input is ready only while no query is in flight. A finished result sits in
// the output register; a new item may be accepted while it waits, and a later
// query holds its own result until the receiver takes the earlier one.
// Reset clears the disk count and the output valid flag; the disk table is not
// cleared and must be loaded before it is searched.
// disk_count is written over the APB port at byte address 0.
module ray_disk_closest_hit #(
    parameter int MAX_DISKS = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               kind,
    input  logic [5:0]         slot,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    input  logic signed [31:0] dir_x,
    input  logic signed [31:0] dir_y,
    input  logic signed [31:0] dir_z,
    input  logic signed [31:0] lower_value,
    input  logic signed [31:0] upper_bound,
    input  logic signed [31:0] best_so_far,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               hit,
    output logic [5:0]         hit_index,
    output logic signed [31:0] closest_t,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int IW = (MAX_DISKS > 1) ? $clog2(MAX_DISKS) : 1;

    logic [6:0]          count_reg;
    logic [IW-1:0]       disk_idx;
    rdch_pkg::rdch_cmd_t cmd;
    rdch_pkg::rdch_sts_t sts;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? 32'(count_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (psel && penable && pwrite && paddr[2] == 1'b0)
        begin
            count_reg <= pwdata[6:0];
        end
    end

    rdch_ctrl #(
        .MAX_DISKS(MAX_DISKS),
        .IW(IW)
    ) u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_kind(kind),
        .count(count_reg),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .disk_idx(disk_idx),
        .cmd(cmd),
        .sts(sts)
    );

    rdch_dpath #(
        .MAX_DISKS(MAX_DISKS),
        .FRAC_BITS(FRAC_BITS),
        .IW(IW)
    ) u_dpath (
        .clk(clk),
        .slot(slot),
        .point_x(point_x),
        .point_y(point_y),
        .point_z(point_z),
        .dir_x(dir_x),
        .dir_y(dir_y),
        .dir_z(dir_z),
        .lower_value(lower_value),
        .upper_bound(upper_bound),
        .best_so_far(best_so_far),
        .disk_idx(disk_idx),
        .cmd(cmd),
        .sts(sts),
        .hit(hit),
        .hit_index(hit_index),
        .closest_t(closest_t)
    );

endmodule

// ----- sv/rdch_ctrl.sv -----
// Sequencer that walks the disk table for each query item.
module rdch_ctrl #(
    parameter int MAX_DISKS = 64,
    parameter int IW = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_kind,
    input  logic [6:0]          count,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [IW-1:0]       disk_idx,
    output rdch_pkg::rdch_cmd_t cmd,
    input  rdch_pkg::rdch_sts_t sts
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_DEN  = 4'd2;
    localparam logic [3:0] S_NUM  = 4'd3;
    localparam logic [3:0] S_DIV  = 4'd4;
    localparam logic [3:0] S_PC   = 4'd5;
    localparam logic [3:0] S_SQ   = 4'd6;
    localparam logic [3:0] S_UPD  = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    localparam logic [5:0] DIV_LAST = 6'(rdch_pkg::QUOT_W + 1);

    logic [3:0]    state_reg, state_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic [IW-1:0] k_reg, k_next;
    logic          ov_reg, ov_next;
    logic [31:0]   eff;
    logic          last_disk;
    logic          accept;

    assign eff = (32'(count) > 32'(MAX_DISKS)) ? 32'(MAX_DISKS) : 32'(count);
    assign last_disk = (32'(k_reg) + 32'd1) >= eff;
    assign in_ready = (state_reg == S_IDLE);
    assign accept = in_valid && in_ready;
    assign out_valid = ov_reg;
    assign disk_idx = k_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        k_next = k_reg;
        ov_next = ov_reg;
        cmd = '0;
        cmd.lane = cnt_reg[1:0];
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                cmd.load_we = accept && !in_kind;
                if (accept && in_kind)
                begin
                    cmd.start = 1'b1;
                    k_next = '0;
                    state_next = (eff == 32'd0) ? S_DONE : S_RD;
                end
            end
            S_RD:
            begin
                cmd.mem_re = 1'b1;
                cnt_next = '0;
                state_next = S_DEN;
            end
            S_DEN, S_NUM, S_PC, S_SQ:
            begin
                cmd.mac = 1'b1;
                case (state_reg)
                    S_DEN:   cmd.phase = rdch_pkg::PH_DEN;
                    S_NUM:   cmd.phase = rdch_pkg::PH_NUM;
                    S_PC:    cmd.phase = rdch_pkg::PH_PC;
                    default: cmd.phase = rdch_pkg::PH_SQ;
                endcase
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg[1:0] == rdch_pkg::LANE_LAST)
                begin
                    cnt_next = '0;
                    case (state_reg)
                        S_DEN:   state_next = S_NUM;
                        S_NUM:   state_next = sts.den_zero ? S_UPD : S_DIV;
                        S_PC:    state_next = S_SQ;
                        default: state_next = S_UPD;
                    endcase
                    // A parallel ray skips straight to the next disk, or finishes the query after the last one.
                    if (state_reg == S_NUM && sts.den_zero)
                    begin
                        if (last_disk)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            k_next = k_reg + IW'(1);
                            state_next = S_RD;
                        end
                    end
                end
            end
            S_DIV:
            begin
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    cmd.div_init = 1'b1;
                end
                else if (cnt_reg != DIV_LAST)
                begin
                    cmd.div_step = 1'b1;
                end
                else
                begin
                    cnt_next = '0;
                    if (!sts.sign_miss)
                    begin
                        state_next = S_PC;
                    end
                    else if (last_disk)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        k_next = k_reg + IW'(1);
                        state_next = S_RD;
                    end
                end
            end
            S_UPD:
            begin
                cmd.upd = 1'b1;
                if (last_disk)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    k_next = k_reg + IW'(1);
                    state_next = S_RD;
                end
            end
            S_DONE:
            begin
                if (!ov_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            k_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            k_reg <= k_next;
            ov_reg <= ov_next;
        end
    end

endmodule

// ----- sv/rdch_dpath.sv -----
// Disk table, shared multiplier, divider and closest hit registers.
module rdch_dpath #(
    parameter int MAX_DISKS = 64,
    parameter int FRAC_BITS = 16,
    parameter int IW = 6
) (
    input  logic                clk,
    input  logic [5:0]          slot,
    input  logic signed [31:0]  point_x,
    input  logic signed [31:0]  point_y,
    input  logic signed [31:0]  point_z,
    input  logic signed [31:0]  dir_x,
    input  logic signed [31:0]  dir_y,
    input  logic signed [31:0]  dir_z,
    input  logic signed [31:0]  lower_value,
    input  logic signed [31:0]  upper_bound,
    input  logic signed [31:0]  best_so_far,
    input  logic [IW-1:0]       disk_idx,
    input  rdch_pkg::rdch_cmd_t cmd,
    output rdch_pkg::rdch_sts_t sts,
    output logic                hit,
    output logic [5:0]          hit_index,
    output logic signed [31:0]  closest_t
);

    localparam int WW = rdch_pkg::WORD_W;
    localparam int AW = rdch_pkg::ACC_W;
    localparam int QW = rdch_pkg::QUOT_W;
    localparam int DW = 96 + FRAC_BITS;

    logic [rdch_pkg::ENTRY_W-1:0] mem [MAX_DISKS];
    logic [rdch_pkg::ENTRY_W-1:0] ent_reg;

    logic signed [WW-1:0] o_reg [3];
    logic signed [WW-1:0] d_reg [3];
    logic signed [WW-1:0] co_reg [3];
    logic signed [WW-1:0] pc_reg [3];
    logic signed [WW-1:0] tmin_reg, tmax_reg, best_reg;
    logic [IW-1:0]        idx_reg;
    logic                 found_reg;

    logic signed [AW-1:0] prod_reg, den_reg, num_reg, sq_reg;
    logic [DW-1:0]        rem_reg, dsh_reg;
    logic [QW-1:0]        q_reg;
    logic                 sat_reg, neg_reg;

    logic signed [WW-1:0] c_w [3];
    logic signed [WW-1:0] n_w [3];
    logic signed [WW-1:0] r2_w;
    logic signed [WW-1:0] mul_a, mul_b, t_w;
    logic signed [AW-1:0] fs, acc_base, acc_sum;
    logic [1:0]           lp;
    logic [AW-1:0]        un, ud;
    logic [DW-1:0]        rem_init, dsh_top;
    logic                 hit_ok;

    function automatic logic signed [WW-1:0] pick3(input logic signed [WW-1:0] a0,
                                                    input logic signed [WW-1:0] a1,
                                                    input logic signed [WW-1:0] a2,
                                                    input logic [1:0] sel);
        if (sel == 2'd2)
        begin
            return a2;
        end
        else if (sel == 2'd1)
        begin
            return a1;
        end
        return a0;
    endfunction

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            c_w[i] = ent_reg[WW*i +: WW];
            n_w[i] = ent_reg[WW*(i+3) +: WW];
        end
    end
    assign r2_w = ent_reg[WW*6 +: WW];

    assign t_w = sat_reg ? 32'sh7FFFFFFF : $signed({1'b0, q_reg});
    assign sts.den_zero = (den_reg == '0);
    assign sts.sign_miss = (t_w != '0) && neg_reg;

    always_comb
    begin
        case (cmd.phase)
            rdch_pkg::PH_DEN:
            begin
                mul_a = pick3(d_reg[0], d_reg[1], d_reg[2], cmd.lane);
                mul_b = pick3(n_w[0], n_w[1], n_w[2], cmd.lane);
            end
            rdch_pkg::PH_NUM:
            begin
                mul_a = pick3(co_reg[0], co_reg[1], co_reg[2], cmd.lane);
                mul_b = pick3(n_w[0], n_w[1], n_w[2], cmd.lane);
            end
            rdch_pkg::PH_PC:
            begin
                mul_a = t_w;
                mul_b = pick3(d_reg[0], d_reg[1], d_reg[2], cmd.lane);
            end
            default:
            begin
                mul_a = pick3(pc_reg[0], pc_reg[1], pc_reg[2], cmd.lane);
                mul_b = mul_a;
            end
        endcase
    end

    // Products are floored to the fixed point grid before they are summed.
    assign fs = prod_reg >>> FRAC_BITS;
    assign lp = cmd.lane - 2'd1;
    always_comb
    begin
        case (cmd.phase)
            rdch_pkg::PH_DEN: acc_base = den_reg;
            rdch_pkg::PH_NUM: acc_base = num_reg;
            default:          acc_base = sq_reg;
        endcase
        if (cmd.lane == 2'd1)
        begin
            acc_base = '0;
        end
    end
    assign acc_sum = acc_base + fs;

    assign un = num_reg[AW-1] ? AW'(-num_reg) : AW'(num_reg);
    assign ud = den_reg[AW-1] ? AW'(-den_reg) : AW'(den_reg);
    assign rem_init = DW'(un) << FRAC_BITS;
    assign dsh_top = DW'(ud) << QW;

    assign hit_ok = (sq_reg <= AW'(r2_w)) && (t_w >= tmin_reg) && (t_w <= tmax_reg)
                    && (t_w < best_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load_we && (32'(slot) < 32'(MAX_DISKS)))
        begin
            mem[IW'(slot)] <= {lower_value, dir_z, dir_y, dir_x, point_z, point_y, point_x};
        end
        if (cmd.mem_re)
        begin
            ent_reg <= mem[disk_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            o_reg[0] <= point_x;
            o_reg[1] <= point_y;
            o_reg[2] <= point_z;
            d_reg[0] <= dir_x;
            d_reg[1] <= dir_y;
            d_reg[2] <= dir_z;
            tmin_reg <= lower_value;
            tmax_reg <= upper_bound;
            best_reg <= best_so_far;
            idx_reg <= '0;
            found_reg <= 1'b0;
        end
        if (cmd.mac && cmd.lane != rdch_pkg::LANE_LAST)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.mac && cmd.phase == rdch_pkg::PH_DEN && cmd.lane == 2'd0)
        begin
            for (int i = 0; i < 3; i++)
            begin
                co_reg[i] <= rdch_pkg::sat32(AW'(c_w[i]) - AW'(o_reg[i]));
            end
        end
        if (cmd.mac && cmd.lane != 2'd0)
        begin
            case (cmd.phase)
                rdch_pkg::PH_DEN: den_reg <= acc_sum;
                rdch_pkg::PH_NUM: num_reg <= acc_sum;
                rdch_pkg::PH_PC:
                begin
                    if (lp == 2'd0)
                    begin
                        pc_reg[0] <= rdch_pkg::sat32(AW'(o_reg[0]) + fs - AW'(c_w[0]));
                    end
                    else if (lp == 2'd1)
                    begin
                        pc_reg[1] <= rdch_pkg::sat32(AW'(o_reg[1]) + fs - AW'(c_w[1]));
                    end
                    else
                    begin
                        pc_reg[2] <= rdch_pkg::sat32(AW'(o_reg[2]) + fs - AW'(c_w[2]));
                    end
                end
                default: sq_reg <= acc_sum;
            endcase
        end
        if (cmd.div_init)
        begin
            rem_reg <= rem_init;
            dsh_reg <= dsh_top >> 1;
            q_reg <= '0;
            sat_reg <= (rem_init >= dsh_top);
            neg_reg <= num_reg[AW-1] ^ den_reg[AW-1];
        end
        if (cmd.div_step)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_reg <= rem_reg - dsh_reg;
                q_reg <= {q_reg[QW-2:0], 1'b1};
            end
            else
            begin
                q_reg <= {q_reg[QW-2:0], 1'b0};
            end
            dsh_reg <= dsh_reg >> 1;
        end
        if (cmd.upd && hit_ok)
        begin
            best_reg <= t_w;
            idx_reg <= disk_idx;
            found_reg <= 1'b1;
        end
        if (cmd.out_load)
        begin
            hit <= found_reg;
            hit_index <= 6'(idx_reg);
            closest_t <= best_reg;
        end
    end

endmodule

// ----- sv/rdch_checker.sv -----
// Port level checks for the ray to disk closest hit block, with its bind.
module rdch_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        kind,
    input logic        out_valid,
    input logic        out_ready,
    input logic        hit,
    input logic [5:0]  hit_index,
    input logic [31:0] closest_t
);

    // A load item never produces a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !kind |=> !$rose(out_valid))
        else $error("result appeared after a load item");

    // A query item keeps the input closed while the table is walked.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && kind |=> !in_ready)
        else $error("input reopened right after a query item");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> hit_index == 6'd0)
        else $error("index reported without a hit");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(closest_t) && $stable(hit))
        else $error("stalled result changed");

endmodule

bind ray_disk_closest_hit rdch_checker u_rdch_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .kind(kind),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .hit(hit),
    .hit_index(hit_index),
    .closest_t(closest_t)
);
